@@ design/circular_queue_engine_defines.svh @@
// Assertion macros used by the circular queue engine execution unit.
`ifndef CIRCULAR_QUEUE_ENGINE_DEFINES_SVH
`define CIRCULAR_QUEUE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CQE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("circular queue engine: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CQE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("circular queue engine: assertion failed");

`endif

@@ design/cqe_pkg.sv @@
// Types and codes shared by the circular queue engine modules.
`default_nettype none
package cqe_pkg;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_DISPLAY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value_in;
    } t_cqe_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic               last;
    } t_cqe_out;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_DISP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

@@ design/cqe_front.sv @@
// Front end: takes requests, decodes them into commands and drops unused codes.
`default_nettype none
module cqe_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  cqe_pkg::t_cqe_in i_req,
    output logic             o_busy,
    input  wire              i_q_full,
    output logic             o_push,
    output cqe_pkg::t_cmd    o_cmd
);
    import cqe_pkg::*;

    logic  r_vld, n_vld;
    t_cmd  r_cmd, n_cmd;
    logic  accept;
    logic  known;
    t_op   dec_op;

    always_comb begin
        known  = 1'b1;
        dec_op = OP_ENQ;
        unique case (i_req.req_type)
            REQ_ENQUEUE: dec_op = OP_ENQ;
            REQ_DEQUEUE: dec_op = OP_DEQ;
            REQ_DISPLAY: dec_op = OP_DISP;
            default:     known  = 1'b0;
        endcase
    end

    assign o_push = r_vld && !i_q_full;
    assign o_busy = r_vld && i_q_full;
    assign accept = i_start && !o_busy;
    assign o_cmd  = r_cmd;

    always_comb begin
        n_vld = o_push ? 1'b0 : r_vld;
        n_cmd = r_cmd;
        if (accept && known) begin
            n_vld       = 1'b1;
            n_cmd.op    = dec_op;
            n_cmd.value = i_req.value_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

@@ design/cqe_cmdq.sv @@
// Two-word command queue between the front end and the execution unit.
`default_nettype none
module cqe_cmdq (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  cqe_pkg::t_cmd      i_cmd,
    input  wire                i_pop,
    output cqe_pkg::t_q_status o_stat,
    output cqe_pkg::t_cmd      o_cmd
);
    import cqe_pkg::*;

    localparam int QD = 2;

    t_cmd       r_slot [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'(QD));
    assign o_cmd        = r_slot[r_rp];
    assign do_pop       = i_pop && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ design/cqe_back.sv @@
// Execution unit: ring buffer store, head/tail pointers and result sequencing.
`default_nettype none
`include "circular_queue_engine_defines.svh"
module cqe_back #(
    parameter int DEPTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  cqe_pkg::t_q_status i_q_stat,
    input  cqe_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_strobe,
    output cqe_pkg::t_cqe_out  o_result
);
    import cqe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_DISP
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic            r_empty, n_empty;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    t_cqe_out        r_out, n_out;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic               fin;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    assign o_strobe = r_out_valid;
    assign o_result = r_out;
    assign fin      = (r_idx == r_tail) || (r_cnt == AW'(DEPTH - 1));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = 1'b0;
        n_out       = r_out;
        rd_addr     = r_head;
        wr_addr     = r_tail;
        wr_en       = 1'b0;
        o_pop       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_stat.valid) begin
                    o_pop           = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out.value_out = '0;
                    n_out.last      = 1'b1;
                    n_out.status    = ST_OK;
                    unique case (i_cmd.op)
                        OP_ENQ: begin
                            if (r_empty) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                n_head  = '0;
                                n_tail  = '0;
                                n_empty = 1'b0;
                            end else if (f_next(r_tail) == r_head) begin
                                n_out.status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = f_next(r_tail);
                                n_tail  = f_next(r_tail);
                            end
                        end
                        OP_DEQ: begin
                            if (r_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                // result leaves once the store read returns
                                n_out_valid = 1'b0;
                                n_state     = S_DEQ;
                                if (r_head == r_tail) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b1;
                                end else begin
                                    n_head = f_next(r_head);
                                end
                            end
                        end
                        OP_DISP: begin
                            if (r_empty) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_idx       = r_head;
                                n_cnt       = '0;
                                n_state     = S_DISP;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_out_valid     = 1'b1;
                n_out.status    = ST_OK;
                n_out.value_out = r_rdata;
                n_out.last      = 1'b1;
                n_state         = S_IDLE;
            end
            S_DISP: begin
                n_out_valid     = 1'b1;
                n_out.status    = ST_OK;
                n_out.value_out = r_rdata;
                n_out.last      = fin;
                if (fin) begin
                    n_state = S_IDLE;
                end else begin
                    // fetch the following word while this one goes out
                    n_idx   = f_next(r_idx);
                    rd_addr = f_next(r_idx);
                    n_cnt   = r_cnt + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    `CQE_ASSERT_IMP(a_empty_ptrs, i_clk, i_rst_n, r_empty, (r_head == '0) && (r_tail == '0))
    `CQE_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == S_IDLE)
    `CQE_ASSERT_NXT(a_deq_out, i_clk, i_rst_n, r_state == S_DEQ, r_out_valid && r_out.last)
    `CQE_ASSERT_IMP(a_walk_on, i_clk, i_rst_n, r_out_valid && !r_out.last, r_state == S_DISP)

endmodule
`default_nettype wire

@@ design/circular_queue_engine.sv @@
// Requests pass the front end register and command queue; the execution unit registers
// each result, and dequeue and display wait for the store read. Display gives one word
// per cycle; enqueue takes 1 request per cycle while the unit is idle. The single
// store read port and the pointer sequencer hold off new commands until a dequeue or
// display ends. Results cannot be stalled; busy rises only when the command queue is
// full. Reset clears pointers, empty flag and queues; the store is not cleared.
`default_nettype none
module circular_queue_engine #(
    parameter int DEPTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  cqe_pkg::t_cqe_in  i_req,
    output logic              o_strobe,
    output cqe_pkg::t_cqe_out o_result
);
    import cqe_pkg::*;

    t_cmd      front_cmd;
    t_cmd      q_cmd;
    t_q_status q_stat;
    logic      push;
    logic      pop;

    cqe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .o_busy   (busy),
        .i_q_full (q_stat.full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    cqe_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_cmd   (q_cmd)
    );

    cqe_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_cmd    (q_cmd),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
